// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pilp_pkg.sv -----
package pilp_pkg;

	localparam int MAX_INDICES_DEF = 12;
	localparam int SLOTS_W = 4;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 4'd12;

	localparam int CHAR_W = 8;
	localparam int VALUE_W = 31;
	localparam int POS_W = 4;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_OPENED,
		PH_NEED_DIGIT,
		PH_IN_NUM,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ST_MORE,
		ST_DONE,
		ST_NO_OPEN,
		ST_DIGIT,
		ST_COMMA,
		ST_TOO_MANY
	} status_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] index_value;
		logic [POS_W-1:0]   index_position;
		logic               value_valid;
		logic               value_stored;
		logic [POS_W-1:0]   index_count;
		status_t            status;
		logic               last;
	} result_t;

endpackage

// ----- src/pilp_in_stage.sv -----
module pilp_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pilp_pkg::CHAR_W-1:0]   in_char,
	input  logic                          advance,
	output logic                          valid_s1,
	output logic [pilp_pkg::CHAR_W-1:0]   char_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

endmodule

// ----- src/pilp_core.sv -----
module pilp_core #(
	parameter int MAX_INDICES = pilp_pkg::MAX_INDICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pilp_pkg::SLOTS_W-1:0]  cfg_data,
	input  logic                          step,
	input  logic [pilp_pkg::CHAR_W-1:0]   char_s1,
	output pilp_pkg::result_t             res
);

	localparam int CNT_W = $clog2(MAX_INDICES + 1);
	localparam int CMP_W = (CNT_W > pilp_pkg::SLOTS_W) ? CNT_W : pilp_pkg::SLOTS_W;

	pilp_pkg::phase_t                 phase_q, phase_d;
	logic [pilp_pkg::VALUE_W-1:0]     acc_q, acc_d;
	logic [CNT_W-1:0]                 cnt_q, cnt_d;
	logic [pilp_pkg::SLOTS_W-1:0]     slots_q;

	logic                             is_digit, is_nul, is_open, is_close, is_comma;
	logic                             at_max;
	logic [pilp_pkg::VALUE_W+3:0]     mul10;
	logic [pilp_pkg::VALUE_W-1:0]     acc_sat;
	pilp_pkg::phase_t                 fin_phase;

	logic                             emit, with_value, last, zero_cnt;
	pilp_pkg::status_t                status;
	logic [CMP_W-1:0]                 cnt_ext, pos_ext, limit_ext, slots_ext, max_ext;

	assign is_digit = (char_s1 >= pilp_pkg::CHAR_ZERO) && (char_s1 <= pilp_pkg::CHAR_NINE);
	assign is_nul   = (char_s1 == pilp_pkg::CHAR_NUL);
	assign is_open  = (char_s1 == pilp_pkg::CHAR_OPEN);
	assign is_close = (char_s1 == pilp_pkg::CHAR_CLOSE);
	assign is_comma = (char_s1 == pilp_pkg::CHAR_COMMA);
	assign at_max   = (cnt_q >= CNT_W'(MAX_INDICES));

	// acc * 10 + digit, clamped at the largest 31-bit value
	assign mul10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (pilp_pkg::VALUE_W+4)'(char_s1[3:0]);
	assign acc_sat = (mul10 > (pilp_pkg::VALUE_W+4)'(pilp_pkg::VALUE_MAX))
		? pilp_pkg::VALUE_MAX : mul10[pilp_pkg::VALUE_W-1:0];

	// a final result on the NUL itself rearms at once
	assign fin_phase = is_nul ? pilp_pkg::PH_SEEK : pilp_pkg::PH_DRAIN;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		case (phase_q)
			pilp_pkg::PH_OPENED, pilp_pkg::PH_NEED_DIGIT: begin
				if (is_digit) begin
					acc_d   = pilp_pkg::VALUE_W'(char_s1[3:0]);
					cnt_d   = cnt_q + CNT_W'(1);
					phase_d = pilp_pkg::PH_IN_NUM;
				end else begin
					phase_d = fin_phase;
				end
			end
			pilp_pkg::PH_IN_NUM: begin
				if (is_digit) begin
					acc_d = acc_sat;
				end else if (is_comma && !at_max) begin
					phase_d = pilp_pkg::PH_NEED_DIGIT;
				end else begin
					phase_d = fin_phase;
				end
			end
			pilp_pkg::PH_DRAIN: begin
				if (is_nul) begin
					phase_d = pilp_pkg::PH_SEEK;
				end
			end
			default: begin
				if (is_open || is_nul) begin
					acc_d = '0;
					cnt_d = '0;
				end
				if (is_open) begin
					phase_d = pilp_pkg::PH_OPENED;
				end else begin
					phase_d = pilp_pkg::PH_SEEK;
				end
			end
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		with_value = 1'b0;
		last       = 1'b1;
		zero_cnt   = 1'b0;
		status     = pilp_pkg::ST_MORE;
		case (phase_q)
			pilp_pkg::PH_OPENED: begin
				emit   = !is_digit;
				status = is_close ? pilp_pkg::ST_DONE : pilp_pkg::ST_DIGIT;
			end
			pilp_pkg::PH_NEED_DIGIT: begin
				emit   = !is_digit;
				status = pilp_pkg::ST_DIGIT;
			end
			pilp_pkg::PH_IN_NUM: begin
				emit       = !is_digit;
				with_value = 1'b1;
				if (is_close) begin
					status = pilp_pkg::ST_DONE;
				end else if (is_comma && at_max) begin
					status = pilp_pkg::ST_TOO_MANY;
				end else if (is_comma) begin
					status = pilp_pkg::ST_MORE;
					last   = 1'b0;
				end else begin
					status = pilp_pkg::ST_COMMA;
				end
			end
			pilp_pkg::PH_DRAIN: begin
				emit = 1'b0;
			end
			default: begin
				emit     = is_nul;
				zero_cnt = 1'b1;
				status   = pilp_pkg::ST_NO_OPEN;
			end
		endcase
	end

	assign cnt_ext   = zero_cnt ? '0 : CMP_W'(cnt_q);
	assign pos_ext   = (cnt_ext != '0) ? cnt_ext - CMP_W'(1) : '0;
	assign slots_ext = CMP_W'(slots_q);
	assign max_ext   = CMP_W'(MAX_INDICES);
	assign limit_ext = (slots_ext > max_ext) ? max_ext : slots_ext;

	always_comb begin
		res.valid          = step && emit;
		res.index_value    = with_value ? acc_q : '0;
		res.index_position = with_value ? pos_ext[pilp_pkg::POS_W-1:0] : '0;
		res.value_valid    = with_value;
		res.value_stored   = with_value && (pos_ext < limit_ext);
		res.index_count    = cnt_ext[pilp_pkg::POS_W-1:0];
		res.status         = status;
		res.last           = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pilp_pkg::PH_SEEK;
			acc_q   <= '0;
			cnt_q   <= '0;
			slots_q <= pilp_pkg::SLOTS_RESET;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
			end
			if (cfg_we) begin
				slots_q <= cfg_data;
			end
		end
	end

endmodule

// ----- src/pilp_out_stage.sv -----
module pilp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  pilp_pkg::result_t  res,
	input  logic               out_ready,
	output logic               advance,
	output logic               valid_s2,
	output pilp_pkg::result_t  res_s2
);

	// the slot frees up in the same cycle its word is taken
	assign advance = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ----- src/paren_index_list_parser.sv -----
// Parenthesised decimal list parser.
// Input stream: one character per word on s_axis (tdata[7:0] = char_code);
// a NUL ends the string. Text before '(' is skipped, then unsigned decimal
// numbers separated by ',' and closed by ')' are parsed.
// Output stream: at most one result word per character on m_axis; tlast
// marks the word that ends the parse of a string. After a final result the
// block swallows characters up to the NUL and then looks for '(' again.
// cfg_we/cfg_data write slots_available; write only while the block is idle.
// Path: a character is taken into the input register, parsed by the core,
// and its result is registered in the result register that drives m_axis.
// Throughput: one character per clock while m_axis does not stall, set by
// the single parse step between the two registers.
// Reset: both stages empty, parser seeking '(', slots_available = 12.
// When m_axis stalls the result holds; s_axis stays ready while the input
// register is empty, then backs up.
module paren_index_list_parser #(
	parameter int MAX_INDICES = pilp_pkg::MAX_INDICES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [pilp_pkg::CHAR_W-1:0]          s_axis_tdata,  // [7:0] char_code
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [30:0] index_value, [34:31] index_position, [35] value_valid,
	// [36] value_stored, [40:37] index_count, [43:41] status, [47:44] zero
	output logic [pilp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_we,
	input  logic [pilp_pkg::SLOTS_W-1:0]         cfg_data
);

	logic                         advance;
	logic                         valid_s1;
	logic [pilp_pkg::CHAR_W-1:0]  char_s1;
	pilp_pkg::result_t            res;
	pilp_pkg::result_t            res_s2;

	pilp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_char  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1)
	);

	pilp_core #(
		.MAX_INDICES (MAX_INDICES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.step     (valid_s1 && advance),
		.char_s1  (char_s1),
		.res      (res)
	);

	pilp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_ready (m_axis_tready),
		.advance   (advance),
		.valid_s2  (m_axis_tvalid),
		.res_s2    (res_s2)
	);

	assign m_axis_tdata = {4'b0, res_s2.status, res_s2.index_count, res_s2.value_stored,
		res_s2.value_valid, res_s2.index_position, res_s2.index_value};
	assign m_axis_tlast = res_s2.last;

endmodule

// ----- src/pilp_checker.sv -----
`include "assert_macros.svh"

module pilp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [pilp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                              m_axis_tlast
);

	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !m_axis_tvalid, "word out during reset")

	`ASSERT_RUN(a_stall_hold, clk, arst_n,
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast), "stalled word changed")

	`ASSERT_RUN(a_last_status, clk, arst_n,
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[43:41] != pilp_pkg::ST_MORE)),
		"tlast disagrees with status")

	`ASSERT_RUN(a_no_value_zero, clk, arst_n,
		m_axis_tvalid && !m_axis_tdata[35] |-> (m_axis_tdata[36:0] == '0),
		"value fields set without a number")

	`ASSERT_RUN(a_more_has_value, clk, arst_n,
		m_axis_tvalid && (m_axis_tdata[43:41] == pilp_pkg::ST_MORE) |-> m_axis_tdata[35],
		"more-coming word without a number")

endmodule

bind paren_index_list_parser pilp_checker u_pilp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

import pilp_pkg::*;

typedef struct {
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;
	logic               value_valid;
	logic               value_stored;
	logic [POS_W-1:0]   count;
	status_t            status;
	logic               last;
} parse_result_t;

class parse_scoreboard;
	phase_t             phase;
	logic [VALUE_W-1:0] acc;
	int unsigned        count;
	logic [SLOTS_W-1:0] slots;
	parse_result_t      due_results[$];
	int                 errors;
	int                 checked;
	int                 with_number;
	int                 status_seen[6];

	function new();
		phase = PH_SEEK;
		acc = '0;
		count = 0;
		slots = SLOTS_RESET;
		errors = 0;
		checked = 0;
		with_number = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
	endfunction

	// Advance the parse by one accepted character; queue the word it causes.
	// Returns 0 when the character is only skipped.
	function bit take_char(logic [CHAR_W-1:0] c);
		bit            digit;
		bit            emit;
		bit            with_num;
		int unsigned   pos;
		int unsigned   limit;
		logic [63:0]   wide;
		parse_result_t r;
		digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		emit = 0;
		with_num = 0;
		r.status = ST_MORE;
		r.last = 1'b1;
		take_char = 1;
		case (phase)
		PH_OPENED, PH_NEED_DIGIT: begin
			if (digit) begin
				acc = VALUE_W'(c - CHAR_ZERO);
				count++;
				phase = PH_IN_NUM;
			end else if (phase == PH_OPENED && c == CHAR_CLOSE) begin
				emit = 1;
				r.status = ST_DONE;
			end else begin
				emit = 1;
				r.status = ST_DIGIT;
			end
		end
		PH_IN_NUM: begin
			if (digit) begin
				wide = 64'(acc) * 64'd10 + 64'(c - CHAR_ZERO);
				acc = (wide > 64'(VALUE_MAX)) ? VALUE_MAX : wide[VALUE_W-1:0];
			end else begin
				emit = 1;
				with_num = 1;
				if (c == CHAR_CLOSE)
					r.status = ST_DONE;
				else if (c == CHAR_COMMA && count >= MAX_INDICES_DEF)
					r.status = ST_TOO_MANY;
				else if (c == CHAR_COMMA) begin
					r.status = ST_MORE;
					r.last = 1'b0;
					phase = PH_NEED_DIGIT;
				end else
					r.status = ST_COMMA;
			end
		end
		PH_DRAIN: begin
			if (c == CHAR_NUL)
				phase = PH_SEEK;
			take_char = 0;
		end
		default: begin
			if (c == CHAR_OPEN) begin
				phase = PH_OPENED;
				acc = '0;
				count = 0;
			end else if (c == CHAR_NUL) begin
				acc = '0;
				count = 0;
				emit = 1;
				r.status = ST_NO_OPEN;
			end else
				take_char = 0;
		end
		endcase
		if (emit) begin
			pos = (count > 0) ? count - 1 : 0;
			limit = (slots > MAX_INDICES_DEF) ? MAX_INDICES_DEF : slots;
			r.value = with_num ? acc : '0;
			r.position = with_num ? pos[POS_W-1:0] : '0;
			r.value_valid = with_num;
			r.value_stored = with_num && (pos < limit);
			r.count = count[POS_W-1:0];
			// a final word on the NUL itself rearms at once
			if (r.last)
				phase = (c == CHAR_NUL) ? PH_SEEK : PH_DRAIN;
			due_results.push_back(r);
		end
	endfunction

	function void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_word(logic [OUT_TDATA_W-1:0] word, logic tlast);
		parse_result_t want;
		if (due_results.size() == 0) begin
			$error("result word %h with nothing expected", word);
			errors++;
			return;
		end
		want = due_results.pop_front();
		checked++;
		if (want.value_valid)
			with_number++;
		status_seen[int'(want.status)]++;
		compare_field("index_value", want.value, word[30:0]);
		compare_field("index_position", want.position, word[34:31]);
		compare_field("value_valid", want.value_valid, word[35]);
		compare_field("value_stored", want.value_stored, word[36]);
		compare_field("index_count", want.count, word[40:37]);
		compare_field("status", want.status, word[43:41]);
		compare_field("padding", 0, word[47:44]);
		compare_field("last", want.last, tlast);
	endfunction
endclass

module tb_top;
	localparam int LIMIT = 500000;
	localparam int SETTLE_CYCLES = 6;
	localparam int TARGET_CHARS = 750;
	localparam int N_SETTINGS = 6;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	logic [SLOTS_W-1:0]     cfg_data;

	parse_scoreboard sb;
	logic [CHAR_W-1:0] text[$];
	bit calm = 0;
	int cycles = 0;
	int taken = 0;
	int worked = 0;
	int hold_left = 0;

	paren_index_list_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("paren_index_list_parser test failed");
			$finish;
		end
	end

	// receiver: random stall bursts, none once calm
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			hold_left <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken++;
				if (sb.take_char(s_axis_tdata))
					worked++;
			end
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata, m_axis_tlast);
		end
	end

	task send_char(input logic [CHAR_W-1:0] c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// stop sending and let every expected word and any quiet character drain
	task settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_slots(input logic [SLOTS_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.slots = v;
	endtask

	function logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(1, 255));
		while (c == CHAR_OPEN);
		return c;
	endfunction

	// Mostly well-formed lists with random numbers; some noise, some damaged.
	function void build_string();
		int kind;
		int n_num;
		int n_dig;
		int cut;
		text.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) text.push_back(CHAR_W'($urandom));
		end else begin
			repeat ($urandom_range(0, 3)) text.push_back(plain_char());
			text.push_back(CHAR_OPEN);
			n_num = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
			for (int i = 0; i < n_num; i++) begin
				if (i > 0)
					text.push_back(CHAR_COMMA);
				n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
				repeat (n_dig) text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
			end
			text.push_back(CHAR_CLOSE);
			if (kind <= 3) begin
				cut = $urandom_range(0, text.size() - 1);
				if ($urandom_range(0, 1))
					text[cut] = CHAR_W'($urandom);
				else
					text = text[0:cut];
			end
			repeat ($urandom_range(0, 2)) text.push_back(plain_char());
		end
		text.push_back(CHAR_NUL);
	endfunction

	initial begin
		logic [SLOTS_W-1:0] slot_plan;
		sb = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_data <= SLOTS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one slot so the second value is not stored
		write_slots(4'd1);
		send_char(CHAR_NUL);
		send_text("x()");
		send_char(CHAR_NUL);
		send_text("(");
		send_char(CHAR_NUL);
		send_text("(9999999999,0)");
		send_char(CHAR_NUL);
		send_text("(4a");
		send_char(CHAR_NUL);

		for (int p = 0; p < N_SETTINGS; p++) begin
			settle();
			case (p)
			0: slot_plan = 4'd0;
			1: slot_plan = 4'd15;
			2: slot_plan = SLOTS_RESET;
			4: slot_plan = 4'd7;
			default: slot_plan = SLOTS_W'($urandom_range(0, 15));
			endcase
			write_slots(slot_plan);
			calm = (p == N_SETTINGS - 1);
			while (taken < TARGET_CHARS * (p + 1) / N_SETTINGS) begin
				build_string();
				foreach (text[i])
					send_char(text[i]);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d characters sent (%0d parsed) under %0d slot settings;",
			taken, worked, N_SETTINGS + 1);
		$display("%0d words checked, %0d with a number", sb.checked, sb.with_number);
		$display("by status: more %0d, done %0d, no paren %0d, digit %0d, comma %0d, too many %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
			sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
		if (sb.errors == 0)
			$display("paren_index_list_parser test passed");
		else
			$display("paren_index_list_parser test failed");
		$finish;
	end
endmodule
